FILE: rtl/mbd_pkg.sv
// Package for the mipmap box downsampler: item structs, register codes and
// shared constants. No dependencies.
`default_nettype none

package mbd_pkg;

  localparam int DEF_MAX_SOURCE_WIDTH = 4096;
  localparam int DEF_MAX_LEVELS       = 12;

  localparam int LANES  = 4;
  localparam int CHAN_W = 8;
  localparam int SUM_W  = 9;
  localparam int LINE_W = LANES * SUM_W;
  localparam int ROW_W  = 12;
  localparam int HGT_W  = 13;
  localparam int CRD_W  = 11;

  localparam logic [HGT_W-1:0] HEIGHT_CAP = 13'd4096;
  localparam logic [9:0]       AVG_MAX    = 10'd255;

  typedef enum logic [1:0] {
    REG_SOURCE_WIDTH  = 2'd0,
    REG_SOURCE_HEIGHT = 2'd1,
    REG_CHANNEL_COUNT = 2'd2,
    REG_MIP_LEVEL     = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [CHAN_W-1:0] chan_0;
    logic [CHAN_W-1:0] chan_1;
    logic [CHAN_W-1:0] chan_2;
    logic [CHAN_W-1:0] chan_3;
  } pixel_t;

  typedef struct packed {
    logic [CRD_W-1:0]  out_x;
    logic [CRD_W-1:0]  out_y;
    logic [CHAN_W-1:0] avg_0;
    logic [CHAN_W-1:0] avg_1;
    logic [CHAN_W-1:0] avg_2;
    logic [CHAN_W-1:0] avg_3;
    logic              level_done;
  } result_t;

  typedef struct packed {
    logic [12:0] source_width;
    logic [12:0] source_height;
    logic [2:0]  channel_count;
    logic [3:0]  mip_level;
  } cfg_t;

  typedef struct packed {
    logic             hold_en;
    logic             use_left;
    logic             wr_top;
    logic             produce;
    logic             add_top;
    logic [1:0]       shift;
    logic [CRD_W-1:0] mx;
    logic [CRD_W-1:0] my;
    logic             done;
  } step_t;

endpackage

`default_nettype wire

FILE: rtl/mbd_addr_gen.sv
// Raster position tracking and box decode for the mipmap box downsampler.
// Depends on mbd_pkg.
`default_nettype none

module mbd_addr_gen import mbd_pkg::*; #(
  parameter int MAX_SOURCE_WIDTH = DEF_MAX_SOURCE_WIDTH,
  parameter int MAX_LEVELS       = DEF_MAX_LEVELS,
  localparam int CW = $clog2(MAX_SOURCE_WIDTH + 1),
  localparam int IW = (MAX_SOURCE_WIDTH / 2 > 1) ? $clog2(MAX_SOURCE_WIDTH / 2) : 1,
  localparam int XW = (CW > 13) ? CW : 13
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire cfg_t          cfg,
  input  wire logic          restart,
  input  wire logic          accept,
  output step_t              step,
  output logic [IW-1:0]      idx
);

  logic [CW-1:0]    col, col_next;
  logic [ROW_W-1:0] row, row_next;

  logic [XW-1:0]    raw_w;
  logic [CW-1:0]    eff_w, mw_s, mw, col_mask, ox, mx;
  logic [HGT_W-1:0] eff_h, mh_s, mh;
  logic [ROW_W-1:0] row_mask, oy, my;
  logic [3:0]       lvl;
  logic             ox_le1, oy_le1, ox1, oy1, col_end, row_end, hit, last_col, last_row;

  assign raw_w = XW'(cfg.source_width);

  always_comb begin
    if (raw_w == '0) begin
      eff_w = CW'(1);
    end else if (raw_w > XW'(MAX_SOURCE_WIDTH)) begin
      eff_w = CW'(MAX_SOURCE_WIDTH);
    end else begin
      eff_w = CW'(raw_w);
    end
    if (cfg.source_height == '0) begin
      eff_h = HGT_W'(1);
    end else if (cfg.source_height > HEIGHT_CAP) begin
      eff_h = HEIGHT_CAP;
    end else begin
      eff_h = cfg.source_height;
    end
    if (cfg.mip_level == '0) begin
      lvl = 4'd1;
    end else if (cfg.mip_level > 4'(MAX_LEVELS)) begin
      lvl = 4'(MAX_LEVELS);
    end else begin
      lvl = cfg.mip_level;
    end
  end

  assign col_mask = CW'((32'd1 << lvl) - 32'd1);
  assign row_mask = ROW_W'((32'd1 << lvl) - 32'd1);
  assign ox       = col & col_mask;
  assign oy       = row & row_mask;
  assign ox_le1   = (ox >> 1) == '0;
  assign oy_le1   = (oy >> 1) == '0;
  assign ox1      = ox_le1 && col[0];
  assign oy1      = oy_le1 && row[0];
  assign mx       = col >> lvl;
  assign my       = row >> lvl;
  assign mw_s     = eff_w >> lvl;
  assign mh_s     = eff_h >> lvl;
  assign mw       = (mw_s == '0) ? CW'(1) : mw_s;
  assign mh       = (mh_s == '0) ? HGT_W'(1) : mh_s;

  assign col_end  = ((CW+1)'(col) + (CW+1)'(1)) >= (CW+1)'(eff_w);
  assign row_end  = ({1'b0, row} + HGT_W'(1)) >= eff_h;
  assign hit      = ox_le1 && oy_le1 && (mx < mw) && (HGT_W'(my) < mh);
  assign last_col = ox1 || col_end;
  assign last_row = oy1 || row_end;

  always_comb begin
    step.hold_en  = hit && !ox1;
    step.use_left = ox1;
    step.wr_top   = hit && last_col && !oy1 && !last_row;
    step.produce  = hit && last_col && last_row;
    step.add_top  = oy1;
    step.shift    = {1'b0, ox1} + {1'b0, oy1};
    step.mx       = CRD_W'(mx);
    step.my       = CRD_W'(my);
    step.done     = (mx == mw - CW'(1)) && (HGT_W'(my) == mh - HGT_W'(1));
  end

  assign idx = mx[IW-1:0];

  always_comb begin
    col_next = col;
    row_next = row;
    if (restart) begin
      col_next = '0;
      row_next = '0;
    end else if (accept) begin
      if (col_end) begin
        col_next = '0;
        row_next = row_end ? '0 : row + ROW_W'(1);
      end else begin
        col_next = col + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else begin
      col <= col_next;
      row <= row_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/mbd_lane.sv
// One channel lane: left pixel hold, row sum and final box average.
// Depends on mbd_pkg.
`default_nettype none

module mbd_lane import mbd_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [CHAN_W-1:0] px,
  input  wire logic              accept,
  input  wire logic              hold_en,
  input  wire logic              use_left,
  input  wire logic              enable,
  input  wire logic              add_top,
  input  wire logic [1:0]        shift,
  input  wire logic [SUM_W-1:0]  top_sum,
  output logic      [SUM_W-1:0]  rowsum,
  output logic      [CHAN_W-1:0] avg
);

  logic [CHAN_W-1:0] left;
  logic [SUM_W-1:0]  s1_sum;
  logic [9:0]        total, scaled;

  assign rowsum = use_left ? SUM_W'(left) + SUM_W'(px) : SUM_W'(px);

  always_ff @(posedge clk) begin
    if (rst) begin
      left <= '0;
    end else if (accept && hold_en) begin
      left <= px;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_sum <= rowsum;
    end
  end

  assign total  = 10'(s1_sum) + (add_top ? 10'(top_sum) : 10'd0);
  assign scaled = total >> shift;

  always_comb begin
    if (!enable) begin
      avg = '0;
    end else if (scaled > AVG_MAX) begin
      avg = CHAN_W'(AVG_MAX);
    end else begin
      avg = scaled[CHAN_W-1:0];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/mbd_line_store.sv
// Line store of partial top-row box sums, one entry per mip column.
// Depends on mbd_pkg.
`default_nettype none

module mbd_line_store import mbd_pkg::*; #(
  parameter int MAX_SOURCE_WIDTH = DEF_MAX_SOURCE_WIDTH,
  localparam int DEPTH = MAX_SOURCE_WIDTH / 2,
  localparam int IW = (MAX_SOURCE_WIDTH / 2 > 1) ? $clog2(MAX_SOURCE_WIDTH / 2) : 1
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [IW-1:0]     wr_addr,
  input  wire logic [LINE_W-1:0] wr_data,
  input  wire logic              rd_en,
  input  wire logic [IW-1:0]     rd_addr,
  output logic      [LINE_W-1:0] rd_data
);

  logic [LINE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/mipmap_box_downsampler.sv
// Pipeline: the item that completes a box passes through the sum stage, then the output
// register, before its result is valid.
// Throughput: one pixel item per cycle while pixel_stall is low; the line store takes one
// write and one registered read per cycle.
// Reset: registers return to width 1, height 1, four channels, level 1; both raster
// counters and the pipeline clear; the line store is not cleared.
// Depends on mbd_pkg, mbd_addr_gen, mbd_lane and mbd_line_store.
`default_nettype none

module mipmap_box_downsampler import mbd_pkg::*; #(
  parameter int MAX_SOURCE_WIDTH = DEF_MAX_SOURCE_WIDTH,
  parameter int MAX_LEVELS       = DEF_MAX_LEVELS
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  input  wire pixel_t      pixel,
  input  wire logic        pixel_valid,
  output logic             pixel_stall,
  output result_t          result,
  output logic             result_valid,
  input  wire logic        result_stall
);

  localparam int IW = (MAX_SOURCE_WIDTH / 2 > 1) ? $clog2(MAX_SOURCE_WIDTH / 2) : 1;

  cfg_t              cfg;
  logic              cfg_wr;
  logic              accept, adv;
  step_t             step;
  logic [IW-1:0]     idx;
  logic [LINE_W-1:0] wr_data, rd_data;
  logic [2:0]        nch;

  logic [LANES-1:0][CHAN_W-1:0] px, avg;
  logic [LANES-1:0][SUM_W-1:0]  rowsum;

  logic              s1_v;
  logic              s1_add_top;
  logic [1:0]        s1_shift;
  logic [CRD_W-1:0]  s1_mx, s1_my;
  logic              s1_done;
  result_t           merged;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.source_width  <= 13'd1;
      cfg.source_height <= 13'd1;
      cfg.channel_count <= 3'd4;
      cfg.mip_level     <= 4'd1;
    end else if (cfg_wr) begin
      case (reg_idx_t'(paddr[3:2]))
        REG_SOURCE_WIDTH:  cfg.source_width  <= pwdata[12:0];
        REG_SOURCE_HEIGHT: cfg.source_height <= pwdata[12:0];
        REG_CHANNEL_COUNT: cfg.channel_count <= pwdata[2:0];
        REG_MIP_LEVEL:     cfg.mip_level     <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_t'(paddr[3:2]))
      REG_SOURCE_WIDTH:  prdata = 32'(cfg.source_width);
      REG_SOURCE_HEIGHT: prdata = 32'(cfg.source_height);
      REG_CHANNEL_COUNT: prdata = 32'(cfg.channel_count);
      REG_MIP_LEVEL:     prdata = 32'(cfg.mip_level);
      default:           prdata = '0;
    endcase
  end

  assign adv         = !result_valid || !result_stall;
  assign pixel_stall = s1_v && !adv;
  assign accept      = pixel_valid && !pixel_stall;

  mbd_addr_gen #(
    .MAX_SOURCE_WIDTH(MAX_SOURCE_WIDTH),
    .MAX_LEVELS      (MAX_LEVELS)
  ) u_addr_gen (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .restart(cfg_wr),
    .accept (accept),
    .step   (step),
    .idx    (idx)
  );

  assign px[0] = pixel.chan_0;
  assign px[1] = pixel.chan_1;
  assign px[2] = pixel.chan_2;
  assign px[3] = pixel.chan_3;
  assign nch   = (cfg.channel_count > 3'd4) ? 3'd4 : cfg.channel_count;

  for (genvar k = 0; k < LANES; k++) begin : g_lane
    mbd_lane u_lane (
      .clk     (clk),
      .rst     (rst),
      .px      (px[k]),
      .accept  (accept),
      .hold_en (step.hold_en),
      .use_left(step.use_left),
      .enable  (3'(k) < nch),
      .add_top (s1_add_top),
      .shift   (s1_shift),
      .top_sum (rd_data[k*SUM_W +: SUM_W]),
      .rowsum  (rowsum[k]),
      .avg     (avg[k])
    );
    assign wr_data[k*SUM_W +: SUM_W] = rowsum[k];
  end

  mbd_line_store #(
    .MAX_SOURCE_WIDTH(MAX_SOURCE_WIDTH)
  ) u_line_store (
    .clk    (clk),
    .wr_en  (accept && step.wr_top),
    .wr_addr(idx),
    .wr_data(wr_data),
    .rd_en  (accept && step.produce && step.add_top),
    .rd_addr(idx),
    .rd_data(rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (accept) begin
      s1_v <= step.produce;
    end else if (adv) begin
      s1_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_add_top <= step.add_top;
      s1_shift   <= step.shift;
      s1_mx      <= step.mx;
      s1_my      <= step.my;
      s1_done    <= step.done;
    end
  end

  always_comb begin
    merged.out_x      = s1_mx;
    merged.out_y      = s1_my;
    merged.avg_0      = avg[0];
    merged.avg_1      = avg[1];
    merged.avg_2      = avg[2];
    merged.avg_3      = avg[3];
    merged.level_done = s1_done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv) begin
      result_valid <= s1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_v) begin
      result <= merged;
    end
  end

  a_produce_fills_stage: assert property (@(posedge clk) disable iff (rst)
    accept && step.produce |=> s1_v)
    else $error("completed box item did not reach the sum stage");

  a_stage_holds: assert property (@(posedge clk) disable iff (rst)
    s1_v && !adv |=> s1_v && $stable(s1_mx) && $stable(s1_my) && $stable(s1_done))
    else $error("blocked sum stage lost or changed its item");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    pixel_stall |-> result_valid && result_stall && s1_v)
    else $error("input stalled while the output side could move");

endmodule

`default_nettype wire
